// File: hdl/gsdc_pkg.sv
// Shared constants for the gamepad stick dead zone conditioner.
`default_nettype none
package gsdc_pkg;
    localparam int QUO_W      = 17;
    localparam int ROOT_W     = 16;
    localparam int ROOT_REM_W = 18;
    localparam int SQ_W       = 32;
    localparam int STICK_LAT  = 56;
    localparam int TRIG_DLY   = STICK_LAT - QUO_W;

    localparam logic [14:0] AXIS_FULL_SCALE = 15'd32767;
    localparam logic [16:0] OFFSET_CENTER   = 17'd32767;
    localparam logic [15:0] NARROW_FULL     = 16'd255;
    localparam logic [15:0] WIDE_FULL       = 16'd65535;
    localparam logic [15:0] OUT_MAX         = 16'hFFFF;

    localparam logic [15:0] HAT_UP    = 16'd0;
    localparam logic [15:0] HAT_RIGHT = 16'd9000;
    localparam logic [15:0] HAT_DOWN  = 16'd18000;
    localparam logic [15:0] HAT_LEFT  = 16'd27000;

    localparam logic [2:0] REG_FORMAT  = 3'd0;
    localparam logic [2:0] REG_LEFT_DZ = 3'd1;
    localparam logic [2:0] REG_RIGHT_DZ = 3'd2;
    localparam logic [2:0] REG_TRIG_NARROW = 3'd3;
    localparam logic [2:0] REG_TRIG_WIDE = 3'd4;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic        xpos;
        logic        ypos;
        logic [14:0] dz;
    } stick_in_t;
endpackage
`default_nettype wire

// File: hdl/gsdc_div_cell.sv
// One restoring division step: one quotient bit per cell.
`default_nettype none
module gsdc_div_cell #(
    parameter int DW = 16,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] div_in,
    input  logic [QW-1:0] bits_in,
    input  logic [SW-1:0] side_in,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] div_out,
    output logic [QW-1:0] bits_out,
    output logic [SW-1:0] side_out
);
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_in, bits_in[QW-1]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = trial >= {1'b0, div_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            div_out  <= div_in;
            bits_out <= {bits_in[QW-2:0], ge};
            side_out <= side_in;
        end
    end
endmodule
`default_nettype wire

// File: hdl/gsdc_root_cell.sv
// One integer square root step: one root bit per cell.
`default_nettype none
module gsdc_root_cell #(
    parameter int SW = 1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gsdc_pkg::ROOT_REM_W-1:0] rem_in,
    input  logic [gsdc_pkg::ROOT_W-1:0]   root_in,
    input  logic [gsdc_pkg::SQ_W-1:0]     sq_in,
    input  logic [SW-1:0]                 side_in,
    output logic [gsdc_pkg::ROOT_REM_W-1:0] rem_out,
    output logic [gsdc_pkg::ROOT_W-1:0]   root_out,
    output logic [gsdc_pkg::SQ_W-1:0]     sq_out,
    output logic [SW-1:0]                 side_out
);
    import gsdc_pkg::*;

    logic [ROOT_REM_W+1:0] cur;
    logic [ROOT_REM_W+1:0] trial;
    logic [ROOT_REM_W+1:0] diff;
    logic                  ge;

    assign cur   = {rem_in, sq_in[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= ge ? diff[ROOT_REM_W-1:0] : cur[ROOT_REM_W-1:0];
            root_out <= {root_in[ROOT_W-2:0], ge};
            sq_out   <= {sq_in[SQ_W-3:0], 2'b00};
            side_out <= side_in;
        end
    end
endmodule
`default_nettype wire

// File: hdl/gsdc_stick.sv
// One stick: magnitude, radial dead zone, squared level and direction split.
`default_nettype none
module gsdc_stick (
    input  logic                  clk,
    input  logic                  en,
    input  gsdc_pkg::stick_in_t   stick,
    output logic [15:0]           x_positive,
    output logic [15:0]           x_negative,
    output logic [15:0]           y_positive,
    output logic [15:0]           y_negative
);
    import gsdc_pkg::*;

    localparam int RSW = 50;
    localparam int LSW = 51;

    logic [31:0] sqx_reg, sqy_reg;
    logic [29:0] dzsq_reg;
    logic [15:0] ax1_reg, ay1_reg;
    logic        xp1_reg, yp1_reg, dzbig_reg;
    logic [14:0] dz1_reg;

    logic [31:0] s_reg;
    logic [15:0] ax2_reg, ay2_reg;
    logic        xp2_reg, yp2_reg, inzone_reg;
    logic [14:0] dz2_reg;

    logic [ROOT_REM_W-1:0] rrem  [0:ROOT_W];
    logic [ROOT_W-1:0]     rroot [0:ROOT_W];
    logic [SQ_W-1:0]       rsq   [0:ROOT_W];
    logic [RSW-1:0]        rside [0:ROOT_W];

    logic [15:0] r_end, ax_end, ay_end;
    logic        xp_end, yp_end, inz_end;
    logic [14:0] dz_end, mc;
    logic        zero_next;

    logic [15:0] r3_reg, ax3_reg, ay3_reg;
    logic [14:0] num_reg, den_reg;
    logic        xp3_reg, yp3_reg, zero3_reg;

    logic [29:0] numsq_reg, densq_reg;
    logic [15:0] r4_reg, ax4_reg, ay4_reg;
    logic        xp4_reg, yp4_reg, zero4_reg;

    logic [29:0]    lrem  [0:QUO_W];
    logic [29:0]    ldiv  [0:QUO_W];
    logic [QUO_W-1:0] lbits [0:QUO_W];
    logic [LSW-1:0] lside [0:QUO_W];

    logic [31:0] px_reg, py_reg;
    logic [15:0] r5_reg;
    logic        xp5_reg, yp5_reg, zero5_reg;

    logic [15:0]      xrem [0:QUO_W], yrem [0:QUO_W];
    logic [15:0]      xdiv [0:QUO_W], ydiv [0:QUO_W];
    logic [QUO_W-1:0] xbits [0:QUO_W], ybits [0:QUO_W];
    logic [1:0]       xside [0:QUO_W], yside [0:QUO_W];

    logic [15:0] vx, vy;
    logic        xz, yz, xp, yp;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= 32'(stick.ax) * 32'(stick.ax);
            sqy_reg   <= 32'(stick.ay) * 32'(stick.ay);
            dzsq_reg  <= 30'(stick.dz) * 30'(stick.dz);
            ax1_reg   <= stick.ax;
            ay1_reg   <= stick.ay;
            xp1_reg   <= stick.xpos;
            yp1_reg   <= stick.ypos;
            dz1_reg   <= stick.dz;
            dzbig_reg <= stick.dz >= AXIS_FULL_SCALE;

            s_reg      <= sqx_reg + sqy_reg;
            inzone_reg <= dzbig_reg || ((sqx_reg + sqy_reg) <= {2'b00, dzsq_reg});
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            xp2_reg    <= xp1_reg;
            yp2_reg    <= yp1_reg;
            dz2_reg    <= dz1_reg;
        end
    end

    assign rrem[0]  = '0;
    assign rroot[0] = '0;
    assign rsq[0]   = s_reg;
    assign rside[0] = {inzone_reg, dz2_reg, yp2_reg, xp2_reg, ay2_reg, ax2_reg};

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        gsdc_root_cell #(.SW(RSW)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rrem[i]),
            .root_in (rroot[i]),
            .sq_in   (rsq[i]),
            .side_in (rside[i]),
            .rem_out (rrem[i+1]),
            .root_out(rroot[i+1]),
            .sq_out  (rsq[i+1]),
            .side_out(rside[i+1])
        );
    end

    assign r_end  = rroot[ROOT_W];
    assign {inz_end, dz_end, yp_end, xp_end, ay_end, ax_end} = rside[ROOT_W];
    assign mc        = (r_end > 16'(AXIS_FULL_SCALE)) ? AXIS_FULL_SCALE : r_end[14:0];
    assign zero_next = inz_end || (mc <= dz_end);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg    <= r_end;
            ax3_reg   <= ax_end;
            ay3_reg   <= ay_end;
            xp3_reg   <= xp_end;
            yp3_reg   <= yp_end;
            zero3_reg <= zero_next;
            num_reg   <= mc - dz_end;
            den_reg   <= AXIS_FULL_SCALE - dz_end;

            numsq_reg <= 30'(num_reg) * 30'(num_reg);
            densq_reg <= 30'(den_reg) * 30'(den_reg);
            r4_reg    <= r3_reg;
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            xp4_reg   <= xp3_reg;
            yp4_reg   <= yp3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    assign lrem[0]  = {1'b0, numsq_reg[29:1]};
    assign ldiv[0]  = densq_reg;
    assign lbits[0] = {numsq_reg[0], 16'b0};
    assign lside[0] = {zero4_reg, yp4_reg, xp4_reg, ay4_reg, ax4_reg, r4_reg};

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_level
        gsdc_div_cell #(.DW(30), .QW(QUO_W), .SW(LSW)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (lrem[i]),
            .div_in  (ldiv[i]),
            .bits_in (lbits[i]),
            .side_in (lside[i]),
            .rem_out (lrem[i+1]),
            .div_out (ldiv[i+1]),
            .bits_out(lbits[i+1]),
            .side_out(lside[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= 32'(lside[QUO_W][31:16]) * 32'(lbits[QUO_W]);
            py_reg    <= 32'(lside[QUO_W][47:32]) * 32'(lbits[QUO_W]);
            r5_reg    <= lside[QUO_W][15:0];
            xp5_reg   <= lside[QUO_W][48];
            yp5_reg   <= lside[QUO_W][49];
            zero5_reg <= lside[QUO_W][50];
        end
    end

    assign xrem[0]  = {1'b0, px_reg[31:17]};
    assign xdiv[0]  = r5_reg;
    assign xbits[0] = px_reg[16:0];
    assign xside[0] = {zero5_reg, xp5_reg};
    assign yrem[0]  = {1'b0, py_reg[31:17]};
    assign ydiv[0]  = r5_reg;
    assign ybits[0] = py_reg[16:0];
    assign yside[0] = {zero5_reg, yp5_reg};

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_axis
        gsdc_div_cell #(.DW(16), .QW(QUO_W), .SW(2)) u_xcell (
            .clk     (clk),
            .en      (en),
            .rem_in  (xrem[i]),
            .div_in  (xdiv[i]),
            .bits_in (xbits[i]),
            .side_in (xside[i]),
            .rem_out (xrem[i+1]),
            .div_out (xdiv[i+1]),
            .bits_out(xbits[i+1]),
            .side_out(xside[i+1])
        );
        gsdc_div_cell #(.DW(16), .QW(QUO_W), .SW(2)) u_ycell (
            .clk     (clk),
            .en      (en),
            .rem_in  (yrem[i]),
            .div_in  (ydiv[i]),
            .bits_in (ybits[i]),
            .side_in (yside[i]),
            .rem_out (yrem[i+1]),
            .div_out (ydiv[i+1]),
            .bits_out(ybits[i+1]),
            .side_out(yside[i+1])
        );
    end

    assign vx = xbits[QUO_W][16] ? OUT_MAX : xbits[QUO_W][15:0];
    assign vy = ybits[QUO_W][16] ? OUT_MAX : ybits[QUO_W][15:0];
    assign {xz, xp} = xside[QUO_W];
    assign {yz, yp} = yside[QUO_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_positive <= (!xz && xp)  ? vx : 16'd0;
            x_negative <= (!xz && !xp) ? vx : 16'd0;
            y_positive <= (!yz && yp)  ? vy : 16'd0;
            y_negative <= (!yz && !yp) ? vy : 16'd0;
        end
    end
endmodule
`default_nettype wire

// File: hdl/gamepad_stick_deadzone_conditioner.sv
// Top level of the gamepad stick dead zone conditioner.
// Takes one controller report per clock and returns one conditioned result per report,
// in order. Each stick runs a 16-cell square root chain, a 17-cell level divider
// chain and a 17-cell direction divider chain, with registered multiplies
// between them. Throughput is one report per cycle; a stalled output holds the whole
// pipeline. Registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16; the
// user must write them only while the pipeline is empty; the block doesn't enforce it.
`default_nettype none
module gamepad_stick_deadzone_conditioner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] left_stick_x,
    input  logic [15:0] left_stick_y,
    input  logic [15:0] right_stick_x,
    input  logic [15:0] right_stick_y,
    input  logic [15:0] trigger_first,
    input  logic [15:0] trigger_second,
    input  logic [15:0] button_bits,
    input  logic [15:0] hat_angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] left_x_positive,
    output logic [15:0] left_x_negative,
    output logic [15:0] left_y_positive,
    output logic [15:0] left_y_negative,
    output logic [15:0] right_x_positive,
    output logic [15:0] right_x_negative,
    output logic [15:0] right_y_positive,
    output logic [15:0] right_y_negative,
    output logic [15:0] left_trigger_level,
    output logic [15:0] right_trigger_level,
    output logic [13:0] pressed_mask
);
    import gsdc_pkg::*;

    logic        fmt_reg;
    logic [14:0] ldz_reg, rdz_reg;
    logic [7:0]  tnar_reg;
    logic [15:0] twide_reg;
    logic        cfg_wr;

    logic               en;
    logic [STICK_LAT:0] vld_reg;

    logic [16:0] lxv, lyv, rxv, ryv;
    stick_in_t   lst_next, rst_next, lst_reg, rst_reg;

    logic [15:0] t16, dabs, tmag, tdiv;
    logic [16:0] d17;
    logic        dpos;
    logic [13:0] mask;

    logic [15:0] tmag_reg, tdiv_reg;
    logic        tleft_reg;
    logic [13:0] mask_reg;

    logic [15:0]      trem  [0:QUO_W];
    logic [15:0]      tdvs  [0:QUO_W];
    logic [QUO_W-1:0] tbits [0:QUO_W];
    logic [0:0]       tside [0:QUO_W];

    logic [QUO_W:0] tdly_reg [0:TRIG_DLY-1];
    logic [13:0]    mdly_reg [0:STICK_LAT-1];
    logic [15:0]    tlvl;

    function automatic logic [16:0] axis_value(input logic [15:0] raw, input logic fmt1,
                                               input logic inv);
        logic [16:0] v;
        if (!fmt1)
            v = {raw[15], raw};
        else if (inv)
            v = OFFSET_CENTER - {1'b0, raw};
        else
            v = {1'b0, raw} - OFFSET_CENTER;
        return v;
    endfunction

    function automatic stick_in_t make_stick(input logic [16:0] xv, input logic [16:0] yv,
                                             input logic [14:0] dz);
        stick_in_t s;
        logic [16:0] xa, ya;
        xa     = xv[16] ? (17'd0 - xv) : xv;
        ya     = yv[16] ? (17'd0 - yv) : yv;
        s.ax   = xa[15:0];
        s.ay   = ya[15:0];
        s.xpos = !xv[16] && (xv != 17'd0);
        s.ypos = !yv[16] && (yv != 17'd0);
        s.dz   = dz;
        return s;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= 1'b0;
            ldz_reg   <= 15'd7849;
            rdz_reg   <= 15'd8689;
            tnar_reg  <= 8'd30;
            twide_reg <= 16'd6553;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_FORMAT:      fmt_reg   <= pwdata[0];
                REG_LEFT_DZ:     ldz_reg   <= pwdata[14:0];
                REG_RIGHT_DZ:    rdz_reg   <= pwdata[14:0];
                REG_TRIG_NARROW: tnar_reg  <= pwdata[7:0];
                REG_TRIG_WIDE:   twide_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FORMAT:      prdata = {31'd0, fmt_reg};
            REG_LEFT_DZ:     prdata = {17'd0, ldz_reg};
            REG_RIGHT_DZ:    prdata = {17'd0, rdz_reg};
            REG_TRIG_NARROW: prdata = {24'd0, tnar_reg};
            REG_TRIG_WIDE:   prdata = {16'd0, twide_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign out_valid = vld_reg[STICK_LAT];
    assign in_stall  = out_valid && out_stall;
    assign en        = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STICK_LAT-1:0], in_valid};
    end

    assign lxv = axis_value(left_stick_x, fmt_reg, 1'b0);
    assign lyv = axis_value(left_stick_y, fmt_reg, 1'b1);
    assign rxv = axis_value(right_stick_x, fmt_reg, 1'b0);
    assign ryv = axis_value(right_stick_y, fmt_reg, 1'b1);
    assign lst_next = make_stick(lxv, lyv, ldz_reg);
    assign rst_next = make_stick(rxv, ryv, fmt_reg ? ldz_reg : rdz_reg);

    assign t16  = fmt_reg ? {1'b0, twide_reg[15:1]} : {9'd0, tnar_reg[7:1]};
    assign d17  = fmt_reg ? ({1'b0, trigger_second} - {1'b0, trigger_first})
                          : ({9'd0, trigger_second[7:0]} - {9'd0, trigger_first[7:0]});
    assign dabs = d17[16] ? 16'(17'd0 - d17) : d17[15:0];
    assign tmag = (dabs < t16) ? 16'd0 : (dabs - t16);
    assign dpos = !d17[16] && (tmag != 16'd0);
    assign tdiv = (fmt_reg ? WIDE_FULL : NARROW_FULL) - t16;

    always_comb
    begin
        if (fmt_reg)
        begin
            mask = {button_bits[9], button_bits[8], button_bits[3], button_bits[2],
                    button_bits[1], button_bits[0],
                    hat_angle == HAT_DOWN, hat_angle == HAT_UP,
                    hat_angle == HAT_RIGHT, hat_angle == HAT_LEFT,
                    button_bits[5], button_bits[4], button_bits[11], button_bits[10]};
        end
        else
        begin
            mask = {button_bits[4], button_bits[5], button_bits[15], button_bits[13],
                    button_bits[12], button_bits[14], button_bits[1], button_bits[0],
                    button_bits[3], button_bits[2], button_bits[9], button_bits[8],
                    button_bits[7], button_bits[6]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lst_reg   <= lst_next;
            rst_reg   <= rst_next;
            tmag_reg  <= tmag;
            tdiv_reg  <= tdiv;
            tleft_reg <= fmt_reg ? dpos : !dpos;
            mask_reg  <= mask;
        end
    end

    gsdc_stick u_left (
        .clk       (clk),
        .en        (en),
        .stick     (lst_reg),
        .x_positive(left_x_positive),
        .x_negative(left_x_negative),
        .y_positive(left_y_positive),
        .y_negative(left_y_negative)
    );

    gsdc_stick u_right (
        .clk       (clk),
        .en        (en),
        .stick     (rst_reg),
        .x_positive(right_x_positive),
        .x_negative(right_x_negative),
        .y_positive(right_y_positive),
        .y_negative(right_y_negative)
    );

    assign trem[0]  = {1'b0, tmag_reg[15:1]};
    assign tdvs[0]  = tdiv_reg;
    assign tbits[0] = {tmag_reg[0], 16'b0};
    assign tside[0] = tleft_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_trig
        gsdc_div_cell #(.DW(16), .QW(QUO_W), .SW(1)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (trem[i]),
            .div_in  (tdvs[i]),
            .bits_in (tbits[i]),
            .side_in (tside[i]),
            .rem_out (trem[i+1]),
            .div_out (tdvs[i+1]),
            .bits_out(tbits[i+1]),
            .side_out(tside[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdly_reg[0] <= {tside[QUO_W], tbits[QUO_W]};
            for (int k = 1; k < TRIG_DLY; k++)
                tdly_reg[k] <= tdly_reg[k-1];
            mdly_reg[0] <= mask_reg;
            for (int k = 1; k < STICK_LAT; k++)
                mdly_reg[k] <= mdly_reg[k-1];
        end
    end

    assign tlvl = tdly_reg[TRIG_DLY-1][16] ? OUT_MAX : tdly_reg[TRIG_DLY-1][15:0];
    assign left_trigger_level  = tdly_reg[TRIG_DLY-1][QUO_W] ? tlvl : 16'd0;
    assign right_trigger_level = tdly_reg[TRIG_DLY-1][QUO_W] ? 16'd0 : tlvl;
    assign pressed_mask = mdly_reg[STICK_LAT-1];
endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the gamepad stick dead zone conditioner: scoreboard with its own predictor.
`default_nettype none
module tb;
    import gsdc_pkg::*;

    typedef struct {
        logic [15:0] lxp, lxn, lyp, lyn, rxp, rxn, ryp, ryn, ltl, rtl;
        logic [13:0] mask;
    } report_out_t;

    typedef struct {
        logic [15:0] lx, ly, rx, ry, tf, ts, btn, hat;
    } report_in_t;

    class report_scoreboard;
        report_out_t pending[$];
        logic        fmt;
        logic [14:0] left_dz, right_dz;
        logic [7:0]  narrow_thr;
        logic [15:0] wide_thr;
        int          errors;

        function new();
            fmt = 1'b0;
            left_dz = 15'd7849;
            right_dz = 15'd8689;
            narrow_thr = 8'd30;
            wide_thr = 16'd6553;
            errors = 0;
        endfunction

        function automatic longint unsigned isqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function automatic void stick(int x, int y, int dz, output logic [15:0] o[4]);
            longint unsigned ax, ay, s, r, mc, num, den, lvl, v;
            for (int i = 0; i < 4; i++) o[i] = '0;
            if (dz >= 32767) return;
            ax = longint'(x < 0 ? -x : x);
            ay = longint'(y < 0 ? -y : y);
            s = ax * ax + ay * ay;
            if (s <= longint'(dz) * dz) return;
            r = isqrt(s);
            mc = r > 32767 ? 32767 : r;
            if (mc <= dz) return;
            num = mc - dz;
            den = longint'(32767 - dz);
            lvl = ((num * num) << 16) / (den * den);
            v = ax * lvl / r;
            if (v > 65535) v = 65535;
            if (x > 0) o[0] = 16'(v); else o[1] = 16'(v);
            v = ay * lvl / r;
            if (v > 65535) v = 65535;
            if (y > 0) o[2] = 16'(v); else o[3] = 16'(v);
        endfunction

        function void note_report(report_in_t a);
            report_out_t e;
            int lx, ly, rx, ry, d, t, full, rdz;
            logic [15:0] o[4];
            longint unsigned mag, lv;
            logic [13:0] m;
            int pos0[14] = '{6, 7, 8, 9, 2, 3, 0, 1, 14, 12, 13, 15, 5, 4};
            int pos1[4] = '{10, 11, 4, 5};
            int face[6] = '{0, 1, 2, 3, 8, 9};
            m = '0;
            if (fmt)
            begin
                lx = int'(a.lx) - 32767;
                ly = 32767 - int'(a.ly);
                rx = int'(a.rx) - 32767;
                ry = 32767 - int'(a.ry);
                rdz = int'(left_dz);
                d = int'(a.ts) - int'(a.tf);
                t = wide_thr / 2;
                full = 65535;
            end
            else
            begin
                lx = int'($signed(a.lx));
                ly = int'($signed(a.ly));
                rx = int'($signed(a.rx));
                ry = int'($signed(a.ry));
                rdz = int'(right_dz);
                d = int'(a.ts[7:0]) - int'(a.tf[7:0]);
                t = narrow_thr / 2;
                full = 255;
            end
            stick(lx, ly, int'(left_dz), o);
            e.lxp = o[0]; e.lxn = o[1]; e.lyp = o[2]; e.lyn = o[3];
            stick(rx, ry, rdz, o);
            e.rxp = o[0]; e.rxn = o[1]; e.ryp = o[2]; e.ryn = o[3];
            if (d < t && d > -t) d = 0;
            else if (d < 0) d += t;
            else d -= t;
            mag = longint'(d < 0 ? -d : d);
            lv = (mag << 16) / longint'(full - t);
            if (lv > 65535) lv = 65535;
            e.ltl = '0;
            e.rtl = '0;
            if ((d > 0) == fmt) e.ltl = 16'(lv); else e.rtl = 16'(lv);
            if (fmt)
            begin
                for (int i = 0; i < 4; i++) m[i] = a.btn[pos1[i]];
                m[4] = a.hat == HAT_LEFT;
                m[5] = a.hat == HAT_RIGHT;
                m[6] = a.hat == HAT_UP;
                m[7] = a.hat == HAT_DOWN;
                for (int i = 0; i < 6; i++) m[8 + i] = a.btn[face[i]];
            end
            else
                for (int i = 0; i < 14; i++) m[i] = a.btn[pos0[i]];
            e.mask = m;
            pending = {pending, e};
        endfunction

        function void check_result(report_out_t g);
            report_out_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transfer, nothing pending", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (g.lxp !== e.lxp) cmp("left_x_positive", e.lxp, g.lxp);
            if (g.lxn !== e.lxn) cmp("left_x_negative", e.lxn, g.lxn);
            if (g.lyp !== e.lyp) cmp("left_y_positive", e.lyp, g.lyp);
            if (g.lyn !== e.lyn) cmp("left_y_negative", e.lyn, g.lyn);
            if (g.rxp !== e.rxp) cmp("right_x_positive", e.rxp, g.rxp);
            if (g.rxn !== e.rxn) cmp("right_x_negative", e.rxn, g.rxn);
            if (g.ryp !== e.ryp) cmp("right_y_positive", e.ryp, g.ryp);
            if (g.ryn !== e.ryn) cmp("right_y_negative", e.ryn, g.ryn);
            if (g.ltl !== e.ltl) cmp("left_trigger_level", e.ltl, g.ltl);
            if (g.rtl !== e.rtl) cmp("right_trigger_level", e.rtl, g.rtl);
            if (g.mask !== e.mask) cmp("pressed_mask", 16'(e.mask), 16'(g.mask));
        endfunction

        function void cmp(string f, logic [15:0] e, logic [15:0] g);
            $display("%0t: %s expected %h got %h", $time, f, e, g);
            errors++;
        endfunction
    endclass

    logic clk, rst_n, psel, penable, pwrite, pready, in_valid, in_stall, out_valid, out_stall;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic [15:0] left_stick_x, left_stick_y, right_stick_x, right_stick_y;
    logic [15:0] trigger_first, trigger_second, button_bits, hat_angle;
    logic [15:0] left_x_positive, left_x_negative, left_y_positive, left_y_negative;
    logic [15:0] right_x_positive, right_x_negative, right_y_positive, right_y_negative;
    logic [15:0] left_trigger_level, right_trigger_level;
    logic [13:0] pressed_mask;

    report_scoreboard sb;
    int  cycles;
    bit  rx_busy;

    gamepad_stick_deadzone_conditioner u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    initial
    begin
        int g;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_busy) out_stall = 1'b0;
            else if (g > 0)
            begin
                out_stall = 1'b1;
                g--;
            end
            else
            begin
                out_stall = 1'b0;
                if ($urandom_range(0, 9) < 3) g = gap_len();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            report_out_t r;
            r.lxp = left_x_positive; r.lxn = left_x_negative;
            r.lyp = left_y_positive; r.lyn = left_y_negative;
            r.rxp = right_x_positive; r.rxn = right_x_negative;
            r.ryp = right_y_positive; r.ryn = right_y_negative;
            r.ltl = left_trigger_level; r.rtl = right_trigger_level;
            r.mask = pressed_mask;
            sb.check_result(r);
        end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_FORMAT: sb.fmt = val[0];
            REG_LEFT_DZ: sb.left_dz = val[14:0];
            REG_RIGHT_DZ: sb.right_dz = val[14:0];
            REG_TRIG_NARROW: sb.narrow_thr = val[7:0];
            REG_TRIG_WIDE: sb.wide_thr = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (STICK_LAT + 10) @(posedge clk);
    endtask

    task automatic send(report_in_t a);
        int g;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        {left_stick_x, left_stick_y, right_stick_x, right_stick_y} = {a.lx, a.ly, a.rx, a.ry};
        {trigger_first, trigger_second, button_bits, hat_angle} = {a.tf, a.ts, a.btn, a.hat};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_report(a);
    endtask

    task automatic idle_in();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [15:0] rnd_axis(logic f);
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return 16'($urandom);
        if (p < 7) return f ? 16'(16'd32767 + $urandom_range(0, 12000) - 6000)
                            : 16'($urandom_range(0, 6000) - 3000);
        return $urandom_range(0, 3) == 0 ? 16'h8000 : (f ? 16'd65535 : 16'h7FFF);
    endfunction

    function automatic report_in_t rnd_report(logic f);
        report_in_t a;
        int t;
        a.lx = rnd_axis(f); a.ly = rnd_axis(f);
        a.rx = rnd_axis(f); a.ry = rnd_axis(f);
        a.tf = 16'($urandom);
        a.ts = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            t = $urandom_range(0, 40) - 20;
            a.ts = 16'(a.tf + t);
        end
        a.btn = 16'($urandom);
        case ($urandom_range(0, 5))
            0: a.hat = HAT_UP;
            1: a.hat = HAT_RIGHT;
            2: a.hat = HAT_DOWN;
            3: a.hat = HAT_LEFT;
            4: a.hat = 16'hFFFF;
            default: a.hat = 16'($urandom);
        endcase
        return a;
    endfunction

    task automatic directed(logic f);
        report_in_t a;
        logic [15:0] c, hi, lo;
        c = f ? 16'd32767 : 16'd0;
        hi = f ? 16'hFFFF : 16'h7FFF;
        lo = f ? 16'h0000 : 16'h8000;
        a = '{c, c, c, c, 16'd0, 16'd0, 16'd0, 16'hFFFF};
        send(a);
        a = '{hi, c, lo, c, 16'hFFFF, 16'd0, 16'hFFFF, HAT_UP};
        send(a);
        a = '{c, hi, c, lo, 16'd0, 16'hFFFF, 16'h5555, HAT_RIGHT};
        send(a);
        a = '{hi, hi, lo, lo, 16'd10, 16'd20, 16'hAAAA, HAT_DOWN};
        send(a);
        a = '{lo, lo, hi, hi, 16'd200, 16'd10, 16'h0F0F, HAT_LEFT};
        send(a);
        a = '{c + 16'd5000, c, c, c + 16'd9000, 16'd100, 16'd114, 16'hF0F0, 16'd9001};
        send(a);
        a = '{c + 16'd7849, c, c, c, 16'd100, 16'd85, 16'd1, 16'd36000};
        send(a);
        a = '{c + 16'd7850, c, c + 16'd8690, c, 16'h1234, 16'h12FF, 16'h8000, 16'd0};
        send(a);
    endtask

    task automatic phase(int n, logic [31:0] fm, logic [31:0] ldz, logic [31:0] rdz,
                         logic [31:0] nt, logic [31:0] wt);
        idle_in();
        drain();
        write_reg(REG_FORMAT, fm);
        write_reg(REG_LEFT_DZ, ldz);
        write_reg(REG_RIGHT_DZ, rdz);
        write_reg(REG_TRIG_NARROW, nt);
        write_reg(REG_TRIG_WIDE, wt);
        directed(fm[0]);
        for (int i = 0; i < n; i++)
        begin
            send(rnd_report(fm[0]));
            if (i == n / 2)
            begin
                idle_in();
                rx_busy = 1'b1;
                while (sb.pending.size() != 0) @(posedge clk);
                rx_busy = 1'b0;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rx_busy = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        {left_stick_x, left_stick_y, right_stick_x, right_stick_y} = '0;
        {trigger_first, trigger_second, button_bits, hat_angle} = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed(1'b0);
        for (int i = 0; i < 150; i++) send(rnd_report(1'b0));
        phase(250, 1, 7849, 8689, 30, 6553);
        phase(250, 0, 0, 32766, 0, 65534);
        phase(250, 1, 32766, 0, 254, 0);
        phase(250, 0, 32766, 0, 254, 65534);
        phase(250, 1, 0, 12345, 7, 65534);
        phase(250, 0, 15000, 3000, 255, 1);
        idle_in();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (STICK_LAT + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
